FILE: sv/i2cm_pkg.sv
// Shared types, command codes and helpers of the I2C master byte engine.
`default_nettype none

package i2cm_pkg;

	// Bits in one data byte on the bus
	localparam int unsigned BYTE_BITS = 8;
	localparam int unsigned BIT_CNT_W = $clog2(BYTE_BITS + 1);

	// Register reset values
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
	localparam logic [7:0] BIT_TICKS_RST   = 8'd2;

	// Register indexes
	localparam logic REG_ACK_TIMEOUT = 1'b0;
	localparam logic REG_BIT_TICKS   = 1'b1;

	// Command codes
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	// Fixed phase lengths in ticks
	localparam logic [7:0] START_SETUP_TICKS = 8'd5;
	localparam logic [7:0] START_HOLD_TICKS  = 8'd6;
	localparam logic [7:0] STOP_SETUP_TICKS  = 8'd6;
	localparam logic [7:0] STOP_HOLD_TICKS   = 8'd6;
	localparam logic [7:0] NACK_LOW_TICKS    = 8'd2;
	localparam logic [7:0] NACK_HIGH_TICKS   = 8'd5;
	localparam logic [7:0] ONE_TICK          = 8'd1;

	// Configuration registers
	typedef struct packed {
		logic [7:0] ack_timeout;
		logic [7:0] bit_ticks;
	} cfg_t;

	// One input item (tdata layout, first field highest)
	typedef struct packed {
		logic       sda_sample;
		logic       give_ack;
		logic [7:0] write_byte;
		logic [2:0] cmd;
	} in_item_t;

	// One result item (tdata layout, first field highest)
	typedef struct packed {
		logic       ack_missing;
		logic [7:0] read_byte;
		logic       done_res;
		logic       busy_res;
		logic       sda_drive;
		logic       sda_level;
		logic       scl_level;
	} res_item_t;

	// Sequencer phases, one-hot
	typedef enum logic [20:0] {
		PH_IDLE = 21'b000000000000000000001,
		ST_A    = 21'b000000000000000000010,
		ST_B    = 21'b000000000000000000100,
		ST_C    = 21'b000000000000000001000,
		SP_A    = 21'b000000000000000010000,
		SP_B    = 21'b000000000000000100000,
		SP_C    = 21'b000000000000001000000,
		SP_D    = 21'b000000000000010000000,
		WR_A    = 21'b000000000000100000000,
		WR_D    = 21'b000000000001000000000,
		WR_H    = 21'b000000000010000000000,
		WR_L    = 21'b000000000100000000000,
		AK_A    = 21'b000000001000000000000,
		AK_B    = 21'b000000010000000000000,
		AK_W    = 21'b000000100000000000000,
		RD_A    = 21'b000001000000000000000,
		RD_H    = 21'b000010000000000000000,
		RD_L    = 21'b000100000000000000000,
		NK_A    = 21'b001000000000000000000,
		NK_B    = 21'b010000000000000000000,
		NK_C    = 21'b100000000000000000000
	} phase_t;

	// Delay counter load for a phase of the given length; zero counts as one tick
	function automatic logic [7:0] hold_cnt(input logic [7:0] ticks);
		hold_cnt = (ticks == 8'd0) ? 8'd0 : ticks - 8'd1;
	endfunction

endpackage

`default_nettype wire

FILE: sv/i2c_master_byte_engine.sv
// The result item of a tick item is registered at the edge that accepts the tick item.
// Throughput: one tick item per cycle; the sequencer state and the output
// register each turn over once per cycle while the result side takes items.
// Reset (arst_n low, asynchronous): phase idle, SCL high, SDA high and driven,
// status cleared, ack_timeout 250, bit_ticks 2, no result pending.
// Top level of the I2C master byte engine.
`default_nettype none

module i2c_master_byte_engine #(
	parameter logic [7:0] ACK_TIMEOUT_INIT = i2cm_pkg::ACK_TIMEOUT_RST,
	parameter logic [7:0] BIT_TICKS_INIT   = i2cm_pkg::BIT_TICKS_RST
) (
	input  wire         clk,
	input  wire         arst_n,
	// tick items in
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,   // cmd[2:0], write_byte[10:3], give_ack[11], sda_sample[12]
	// result items out
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // scl_level[0], sda_level[1], sda_drive[2], busy_res[3],
	                                    // done_res[4], read_byte[12:5], ack_missing[13]
	// register writes
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [7:0]  cfg_data
);
	import i2cm_pkg::*;

	cfg_t      cfg_q;
	in_item_t  item;
	res_item_t res, res_q;
	logic      adv;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_timeout <= ACK_TIMEOUT_INIT;
			cfg_q.bit_ticks   <= BIT_TICKS_INIT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data;
				REG_BIT_TICKS:   cfg_q.bit_ticks   <= cfg_data;
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	// Input side: take an item whenever the output register is free or draining
	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign adv           = s_axis_tvalid && s_axis_tready;
	assign item          = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);

	i2cm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (s_axis_tready) begin
			m_axis_tvalid <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_axis_tdata = {{(16 - $bits(res_item_t)){1'b0}}, res_q};

endmodule

`default_nettype wire

FILE: sv/i2cm_seq.sv
// Bus sequencer of the I2C master: phase state, counters, line and status registers.
`default_nettype none

module i2cm_seq (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        adv,      // one tick item accepted
	input  wire i2cm_pkg::in_item_t    item,
	input  wire i2cm_pkg::cfg_t        cfg,
	output i2cm_pkg::res_item_t        res       // result of this tick, valid with adv
);
	import i2cm_pkg::*;

	phase_t               phase_q, phase_d;
	logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d, bit_cnt_inc;
	logic [7:0]           shift_q, shift_d;
	logic [7:0]           delay_q, delay_d;
	logic [7:0]           wait_q, wait_d;
	logic                 scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
	logic [7:0]           rd_byte_q, rd_byte_d;
	logic                 ack_miss_q, ack_miss_d;
	logic                 ack_latch_q, ack_latch_d;
	logic                 act, done;
	phase_t               act_phase;

	assign bit_cnt_inc = bit_cnt_q + BIT_CNT_W'(1);

	// Next state for one tick
	always_comb begin
		phase_d     = phase_q;
		bit_cnt_d   = bit_cnt_q;
		shift_d     = shift_q;
		delay_d     = delay_q;
		wait_d      = wait_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		drv_d       = drv_q;
		rd_byte_d   = rd_byte_q;
		ack_miss_d  = ack_miss_q;
		ack_latch_d = ack_latch_q;
		act         = 1'b0;
		act_phase   = phase_q;
		done        = 1'b0;

		// pick the phase whose action runs this tick
		if (phase_q == PH_IDLE) begin
			act = 1'b1;
			case (item.cmd)
				CMD_START: act_phase = ST_A;
				CMD_STOP:  act_phase = SP_A;
				CMD_WRITE: act_phase = WR_A;
				CMD_READ:  act_phase = RD_A;
				default:   act = 1'b0;
			endcase
		end else if (delay_q != 8'd0) begin
			delay_d = delay_q - 8'd1;
		end else begin
			act = 1'b1;
		end

		if (act) begin
			case (act_phase)
				ST_A: begin
					drv_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
					delay_d = hold_cnt(START_SETUP_TICKS); phase_d = ST_B;
				end
				ST_B: begin
					sda_d = 1'b0; delay_d = hold_cnt(START_HOLD_TICKS); phase_d = ST_C;
				end
				ST_C: begin
					scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
				end
				SP_A: begin
					drv_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
					delay_d = hold_cnt(ONE_TICK); phase_d = SP_B;
				end
				SP_B: begin
					scl_d = 1'b1; delay_d = hold_cnt(STOP_SETUP_TICKS); phase_d = SP_C;
				end
				SP_C: begin
					sda_d = 1'b1; delay_d = hold_cnt(STOP_HOLD_TICKS); phase_d = SP_D;
				end
				SP_D: begin
					phase_d = PH_IDLE; done = 1'b1;
				end
				WR_A: begin
					drv_d = 1'b1; scl_d = 1'b0; shift_d = item.write_byte;
					bit_cnt_d = '0; ack_miss_d = 1'b0;
					delay_d = hold_cnt(ONE_TICK); phase_d = WR_D;
				end
				WR_D: begin
					sda_d = shift_q[7];
					shift_d = {shift_q[6:0], 1'b0};
					delay_d = hold_cnt(ONE_TICK); phase_d = WR_H;
				end
				WR_H: begin
					scl_d = 1'b1; delay_d = hold_cnt(cfg.bit_ticks); phase_d = WR_L;
				end
				WR_L: begin
					scl_d = 1'b0; bit_cnt_d = bit_cnt_inc;
					delay_d = hold_cnt(cfg.bit_ticks);
					phase_d = (bit_cnt_inc >= BIT_CNT_W'(BYTE_BITS)) ? AK_A : WR_D;
				end
				AK_A: begin
					drv_d = 1'b0; sda_d = 1'b1;
					delay_d = hold_cnt(ONE_TICK); phase_d = AK_B;
				end
				AK_B: begin
					scl_d = 1'b1; wait_d = 8'd0;
					delay_d = hold_cnt(ONE_TICK); phase_d = AK_W;
				end
				AK_W: begin
					if (!item.sda_sample) begin
						scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
					end else if (wait_q >= cfg.ack_timeout) begin
						// no acknowledge: flag it and run the stop right away
						ack_miss_d = 1'b1;
						drv_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
						delay_d = hold_cnt(ONE_TICK); phase_d = SP_B;
					end else begin
						wait_d = wait_q + 8'd1; delay_d = 8'd0;
					end
				end
				RD_A: begin
					drv_d = 1'b0; sda_d = 1'b1; scl_d = 1'b0; shift_d = 8'd0;
					bit_cnt_d = '0; ack_latch_d = item.give_ack;
					delay_d = hold_cnt(cfg.bit_ticks); phase_d = RD_H;
				end
				RD_H: begin
					scl_d = 1'b1;
					shift_d = {shift_q[6:0], item.sda_sample};
					bit_cnt_d = bit_cnt_inc;
					delay_d = hold_cnt(cfg.bit_ticks);
					phase_d = (bit_cnt_inc >= BIT_CNT_W'(BYTE_BITS)) ? NK_A : RD_L;
				end
				RD_L: begin
					scl_d = 1'b0; delay_d = hold_cnt(cfg.bit_ticks); phase_d = RD_H;
				end
				NK_A: begin
					scl_d = 1'b0; drv_d = 1'b1; sda_d = !ack_latch_q;
					delay_d = hold_cnt(NACK_LOW_TICKS); phase_d = NK_B;
				end
				NK_B: begin
					scl_d = 1'b1; delay_d = hold_cnt(NACK_HIGH_TICKS); phase_d = NK_C;
				end
				NK_C: begin
					scl_d = 1'b0; rd_byte_d = shift_q; phase_d = PH_IDLE; done = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Result of this tick
	always_comb begin
		res.scl_level   = scl_d;
		res.sda_level   = sda_d;
		res.sda_drive   = drv_d;
		res.busy_res    = (phase_d != PH_IDLE);
		res.done_res    = done;
		res.read_byte   = rd_byte_d;
		res.ack_missing = ack_miss_d;
	end

	// State registers, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_cnt_q   <= '0;
			shift_q     <= 8'd0;
			delay_q     <= 8'd0;
			wait_q      <= 8'd0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			drv_q       <= 1'b1;
			rd_byte_q   <= 8'd0;
			ack_miss_q  <= 1'b0;
			ack_latch_q <= 1'b0;
		end else if (adv) begin
			phase_q     <= phase_d;
			bit_cnt_q   <= bit_cnt_d;
			shift_q     <= shift_d;
			delay_q     <= delay_d;
			wait_q      <= wait_d;
			scl_q       <= scl_d;
			sda_q       <= sda_d;
			drv_q       <= drv_d;
			rd_byte_q   <= rd_byte_d;
			ack_miss_q  <= ack_miss_d;
			ack_latch_q <= ack_latch_d;
		end
	end

	// A low acknowledge sample ends the write with SCL low
	a_ack_seen: assert property (@(posedge clk) disable iff (!arst_n)
		adv && phase_q == AK_W && delay_q == 8'd0 && !item.sda_sample
		|=> phase_q == PH_IDLE && !scl_q)
		else $error("acknowledge did not end the write");

	// The missing-ack flag only rises out of the acknowledge wait
	a_miss_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ack_miss_q) |-> $past(phase_q) == AK_W && phase_q == SP_B)
		else $error("ack_missing set outside acknowledge wait");

	// The read byte only changes when a read completes
	a_rd_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(rd_byte_q) |-> $past(phase_q) == NK_C && phase_q == PH_IDLE)
		else $error("read byte changed outside read completion");

endmodule

`default_nettype wire
